// ===== rtl/cllb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the cell list binning unit.
// No dependencies; every other file in rtl/ except cllb_ram imports this package.
package cllb_pkg;

  // Field widths fixed by the request and result formats
  localparam int ID_W      = 10;
  localparam int CQ_W      = 12;
  localparam int POS_W     = 32;
  localparam int CELLS_W   = 13;
  localparam int LINK_W    = ID_W + 1;  // valid bit over particle id
  localparam int CELL_W    = 16;        // widest flat cell address
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;

  // Defaults for top-level parameters
  localparam int DEF_MAX_CELLS     = 4096;
  localparam int DEF_MAX_PARTICLES = 1024;
  localparam int DEF_QUEUE_DEPTH   = 8;

  // Request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_CLEAR  = 2'd1;
  localparam logic [1:0] REQ_HEAD   = 2'd2;
  localparam logic [1:0] REQ_LINK   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_PITCH_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_PITCH_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_PITCH_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y     = 3'd7;

  // Request transaction payload
  typedef struct packed {
    logic [1:0]              req_type;
    logic [ID_W-1:0]         particle_id;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [CQ_W-1:0]         cell_query;
  } req_t;

  // Result transaction payload
  typedef struct packed {
    logic [CQ_W-1:0] bin_index;
    logic [ID_W-1:0] link;
    logic            link_valid;
    logic            out_of_range;
  } rsp_t;

  // Classified job handed from front end to back end
  typedef struct packed {
    logic [1:0]        kind;
    logic              ok;
    logic [ID_W-1:0]   pid;
    logic [CELL_W-1:0] bin_addr;
  } job_t;

  // Job queue status
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

// ===== rtl/cell_list_binning_unit.sv =====
`timescale 1ns / 1ps
// Top level of the cell list binning unit: front end, job queue, back end.
// Depends on cllb_pkg, cllb_front, cllb_queue, cllb_back and cllb_ram.
//
//   channel   handshake                 payload
//   request   start, busy               request (req_t)
//   config    cfg_valid, cfg_ready      cfg_index, cfg_data
//   result    done (one-cycle strobe)   result (rsp_t)
//
// A request transaction passes four index stages (the first loaded at the
// accepting edge), the job queue and the back end's idle and execute states
// before done rises.
// The back end takes no new insert or query until the last one has left its
// execute state, as the head table is read and then written on its single write
// port; a clear holds the back end while its sweep zeroes every head.
// After reset a clearing pass runs with busy high; configuration writes are
// taken throughout. busy also rises when QUEUE_DEPTH transactions are in
// flight. Results cannot be stalled.
module cell_list_binning_unit #(
  parameter int MAX_CELLS     = cllb_pkg::DEF_MAX_CELLS,
  parameter int MAX_PARTICLES = cllb_pkg::DEF_MAX_PARTICLES,
  parameter int QUEUE_DEPTH   = cllb_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  cllb_pkg::req_t                 request,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cllb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cllb_pkg::CFG_W-1:0]     cfg_data,
  output logic                           done,
  output cllb_pkg::rsp_t                 result
);
  import cllb_pkg::*;

  logic    accept;
  logic    front_full;
  logic    push;
  job_t    push_job;
  job_t    head_job;
  q_stat_t q_stat;
  logic    pop;
  logic    init_busy;

  assign cfg_ready = 1'b1;
  assign busy      = init_busy || front_full;
  assign accept    = start && !busy;

  cllb_front #(
    .MAX_CELLS     (MAX_CELLS),
    .MAX_PARTICLES (MAX_PARTICLES),
    .QUEUE_DEPTH   (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .request   (request),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pop       (pop),
    .full      (front_full),
    .push      (push),
    .push_job  (push_job)
  );

  cllb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .stat     (q_stat)
  );

  cllb_back #(
    .MAX_CELLS     (MAX_CELLS),
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_stat.empty),
    .q_job     (head_job),
    .pop       (pop),
    .init_busy (init_busy),
    .done      (done),
    .result    (result)
  );

  // Credit count keeps the queue from overflowing
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("job pushed into a full queue");

  // No result leaves while the post-reset sweep runs
  a_quiet_during_init: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> !done)
    else $error("result strobe during initial clearing pass");

  // The initial sweep holds off requests right after reset
  a_busy_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> busy)
    else $error("request port open right after reset");

endmodule

// ===== rtl/cllb_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cllb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/cllb_queue.sv =====
`timescale 1ns / 1ps
// Small FIFO of classified jobs between front end and back end.
// Depends on cllb_pkg for job_t and q_stat_t.
module cllb_queue #(
  parameter int DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cllb_pkg::job_t    push_job,
  input  logic              pop,
  output cllb_pkg::job_t    head_job,
  output cllb_pkg::q_stat_t stat
);
  import cllb_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  job_t          slots [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == LAST) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == LAST) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_job;
    end
  end

  assign head_job   = slots[rptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == CW'(DEPTH));

endmodule

// ===== rtl/cllb_front.sv =====
`timescale 1ns / 1ps
// Front end: configuration registers, cell index pipeline and job classification.
// Depends on cllb_pkg; feeds cllb_queue.
module cllb_front #(
  parameter int MAX_CELLS     = cllb_pkg::DEF_MAX_CELLS,
  parameter int MAX_PARTICLES = cllb_pkg::DEF_MAX_PARTICLES,
  parameter int QUEUE_DEPTH   = cllb_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  cllb_pkg::req_t                 request,
  input  logic                           cfg_valid,
  input  logic [cllb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cllb_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           pop,
  output logic                           full,
  output logic                           push,
  output cllb_pkg::job_t                 push_job
);
  import cllb_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0]      kind;
    logic [ID_W-1:0] pid;
    logic [CQ_W-1:0] cq;
  } tag_t;

  // Configuration registers
  logic [POS_W-1:0]   offset_x, offset_y, offset_z;
  logic [POS_W-1:0]   inv_pitch_x, inv_pitch_y, inv_pitch_z;
  logic [CELLS_W-1:0] cells_x, cells_y;

  // Pipeline registers
  logic              a_valid, b_valid, c_valid, d_valid;
  tag_t              a_tag, b_tag, c_tag, d_tag;
  logic [POS_W:0]    a_sum_x, a_sum_y, a_sum_z;
  logic [2:0]        b_neg;
  logic [POS_W-1:0]  b_idx_x, b_idx_y, b_idx_z;
  logic              c_ok;
  logic [12:0]       c_ix;
  logic [25:0]       c_iycx;
  logic [25:0]       c_cxy;
  logic [POS_W-1:0]  c_iz;
  logic              d_ok;
  logic [26:0]       d_ixy;
  logic [57:0]       d_izp;
  logic [CNT_W-1:0]  outstanding;

  // Combinational stage logic
  logic [63:0] prod_x, prod_y, prod_z;
  logic [58:0] flat;
  logic        in_grid;
  logic        pid_ok;
  logic        cq_ok;

  // Hold configuration, to be written only while idle: the user must ensure this, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x    <= '0;
      offset_y    <= '0;
      offset_z    <= '0;
      inv_pitch_x <= 32'd65536;
      inv_pitch_y <= 32'd65536;
      inv_pitch_z <= 32'd65536;
      cells_x     <= 13'd16;
      cells_y     <= 13'd16;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_OFFSET_X:    offset_x    <= cfg_data;
        CFG_OFFSET_Y:    offset_y    <= cfg_data;
        CFG_OFFSET_Z:    offset_z    <= cfg_data;
        CFG_INV_PITCH_X: inv_pitch_x <= cfg_data;
        CFG_INV_PITCH_Y: inv_pitch_y <= cfg_data;
        CFG_INV_PITCH_Z: inv_pitch_z <= cfg_data;
        CFG_CELLS_X:     cells_x     <= cfg_data[CELLS_W-1:0];
        CFG_CELLS_Y:     cells_y     <= cfg_data[CELLS_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance stage valid bits and track transactions not yet popped by the back end
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid     <= 1'b0;
      b_valid     <= 1'b0;
      c_valid     <= 1'b0;
      d_valid     <= 1'b0;
      outstanding <= '0;
    end else begin
      a_valid <= accept;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
      if (accept && !pop) begin
        outstanding <= outstanding + 1'b1;
      end else if (pop && !accept) begin
        outstanding <= outstanding - 1'b1;
      end
    end
  end

  assign full = (outstanding == CNT_W'(QUEUE_DEPTH));

  // Per-axis scaling
  assign prod_x = 64'(a_sum_x[POS_W-1:0]) * 64'(inv_pitch_x);
  assign prod_y = 64'(a_sum_y[POS_W-1:0]) * 64'(inv_pitch_y);
  assign prod_z = 64'(a_sum_z[POS_W-1:0]) * 64'(inv_pitch_z);

  // Stage payloads: offset add, scale, bound and partial products, final multiply
  always_ff @(posedge clk) begin
    a_tag   <= '{kind: request.req_type, pid: request.particle_id, cq: request.cell_query};
    a_sum_x <= {request.pos_x[POS_W-1], request.pos_x} + {offset_x[POS_W-1], offset_x};
    a_sum_y <= {request.pos_y[POS_W-1], request.pos_y} + {offset_y[POS_W-1], offset_y};
    a_sum_z <= {request.pos_z[POS_W-1], request.pos_z} + {offset_z[POS_W-1], offset_z};

    b_tag   <= a_tag;
    b_neg   <= {a_sum_z[POS_W], a_sum_y[POS_W], a_sum_x[POS_W]};
    b_idx_x <= prod_x[63:32];
    b_idx_y <= prod_y[63:32];
    b_idx_z <= prod_z[63:32];

    c_tag  <= b_tag;
    c_ok   <= (b_neg == 3'b000) && (b_idx_x < 32'(cells_x)) && (b_idx_y < 32'(cells_y));
    c_ix   <= b_idx_x[12:0];
    c_iycx <= 26'(b_idx_y[12:0]) * 26'(cells_x);
    c_cxy  <= 26'(cells_x) * 26'(cells_y);
    c_iz   <= b_idx_z;

    d_tag <= c_tag;
    d_ok  <= c_ok;
    d_ixy <= 27'(c_ix) + 27'(c_iycx);
    d_izp <= 58'(c_iz) * 58'(c_cxy);
  end

  // Classify the finished item
  assign flat    = 59'(d_izp) + 59'(d_ixy);
  assign in_grid = d_ok && (flat < 59'(MAX_CELLS));
  assign pid_ok  = (32'(d_tag.pid) < 32'(MAX_PARTICLES));
  assign cq_ok   = (32'(d_tag.cq) < 32'(MAX_CELLS));

  always_comb begin
    push_job      = '0;
    push_job.kind = d_tag.kind;
    push_job.pid  = d_tag.pid;
    case (d_tag.kind)
      REQ_INSERT: begin
        push_job.ok       = in_grid && pid_ok;
        push_job.bin_addr = flat[CELL_W-1:0];
      end
      REQ_CLEAR: begin
        push_job.ok = 1'b1;
      end
      REQ_HEAD: begin
        push_job.ok       = cq_ok;
        push_job.bin_addr = CELL_W'(d_tag.cq);
      end
      REQ_LINK: begin
        push_job.ok = pid_ok;
      end
      default: ;
    endcase
  end

  assign push = d_valid;

endmodule

// ===== rtl/cllb_back.sv =====
`timescale 1ns / 1ps
// Back end: head and link tables, insert/query sequencer, clearing sweep.
// Depends on cllb_pkg and cllb_ram; drains cllb_queue.
module cllb_back #(
  parameter int MAX_CELLS     = cllb_pkg::DEF_MAX_CELLS,
  parameter int MAX_PARTICLES = cllb_pkg::DEF_MAX_PARTICLES
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  cllb_pkg::job_t q_job,
  output logic           pop,
  output logic           init_busy,
  output logic           done,
  output cllb_pkg::rsp_t result
);
  import cllb_pkg::*;

  localparam int CAW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int PAW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam logic [CAW-1:0] SWEEP_LAST = CAW'(MAX_CELLS - 1);

  typedef enum logic [1:0] {ST_INIT, ST_IDLE, ST_EXEC, ST_CLEAR} state_t;

  state_t         state;
  logic [CAW-1:0] sweep;
  job_t           job;

  logic              head_we;
  logic [CAW-1:0]    head_waddr;
  logic [LINK_W-1:0] head_wdata;
  logic [LINK_W-1:0] head_rdata;
  logic              next_we;
  logic [LINK_W-1:0] next_rdata;
  logic              ins_ok;
  rsp_t              exec_rsp;

  // Head per cell: {valid, particle id}
  cllb_ram #(.WIDTH(LINK_W), .DEPTH(MAX_CELLS), .AW(CAW)) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .raddr (CAW'(q_job.bin_addr)),
    .rdata (head_rdata)
  );

  // Next link per particle: {valid, particle id}
  cllb_ram #(.WIDTH(LINK_W), .DEPTH(MAX_PARTICLES), .AW(PAW)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (PAW'(job.pid)),
    .wdata (head_rdata),
    .raddr (PAW'(q_job.pid)),
    .rdata (next_rdata)
  );

  assign pop       = (state == ST_IDLE) && !q_empty;
  assign init_busy = (state == ST_INIT);
  assign ins_ok    = (job.kind == REQ_INSERT) && job.ok;
  assign next_we   = (state == ST_EXEC) && ins_ok;

  // Drive the head table write port: sweep zeros or link a new head
  always_comb begin
    head_we    = 1'b0;
    head_waddr = sweep;
    head_wdata = '0;
    case (state)
      ST_INIT, ST_CLEAR: begin
        head_we = 1'b1;
      end
      ST_EXEC: begin
        if (ins_ok) begin
          head_we    = 1'b1;
          head_waddr = CAW'(job.bin_addr);
          head_wdata = {1'b1, job.pid};
        end
      end
      default: ;
    endcase
  end

  // Form the result from the table read data
  always_comb begin
    exec_rsp = '0;
    case (job.kind)
      REQ_INSERT: begin
        if (job.ok) begin
          exec_rsp.bin_index  = job.bin_addr[CQ_W-1:0];
          exec_rsp.link_valid = head_rdata[ID_W];
          exec_rsp.link       = head_rdata[ID_W] ? head_rdata[ID_W-1:0] : '0;
        end else begin
          exec_rsp.out_of_range = 1'b1;
        end
      end
      REQ_HEAD: begin
        exec_rsp.bin_index = job.bin_addr[CQ_W-1:0];
        if (job.ok && head_rdata[ID_W]) begin
          exec_rsp.link_valid = 1'b1;
          exec_rsp.link       = head_rdata[ID_W-1:0];
        end
      end
      REQ_LINK: begin
        if (job.ok && next_rdata[ID_W]) begin
          exec_rsp.link_valid = 1'b1;
          exec_rsp.link       = next_rdata[ID_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // Sequence jobs, sweeps and result strobes
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      sweep <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_INIT: begin
          if (sweep == SWEEP_LAST) begin
            state <= ST_IDLE;
          end else begin
            sweep <= sweep + 1'b1;
          end
        end
        ST_IDLE: begin
          if (!q_empty) begin
            job <= q_job;
            if (q_job.kind == REQ_CLEAR) begin
              sweep <= '0;
              state <= ST_CLEAR;
            end else begin
              state <= ST_EXEC;
            end
          end
        end
        ST_EXEC: begin
          done   <= 1'b1;
          result <= exec_rsp;
          state  <= ST_IDLE;
        end
        ST_CLEAR: begin
          if (sweep == SWEEP_LAST) begin
            done   <= 1'b1;
            result <= '0;
            state  <= ST_IDLE;
          end else begin
            sweep <= sweep + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== bench/cell_list_binning_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for cell_list_binning_unit: directed and random request streams
// checked against an in-bench linked cell list predictor. Depends on cllb_pkg and the RTL.
module cell_list_binning_unit_tb;
  import cllb_pkg::*;

  localparam int N_CELLS     = DEF_MAX_CELLS;
  localparam int N_PARTICLES = DEF_MAX_PARTICLES;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 start     = 1'b0;
  logic                 busy;
  req_t                 request   = '0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 done;
  rsp_t                 result;

  cell_list_binning_unit #(
    .MAX_CELLS(N_CELLS),
    .MAX_PARTICLES(N_PARTICLES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Predictor copy of the geometry registers
  logic [31:0] grid_offset [3];
  logic [31:0] grid_inv_pitch [3];
  logic [12:0] grid_cells_x;
  logic [12:0] grid_cells_y;

  // Predictor copy of the linked cell lists
  logic [ID_W-1:0]       head_id [N_CELLS];
  bit [N_CELLS-1:0]      head_vld;
  logic [LINK_W-1:0]     next_link [N_PARTICLES];
  bit [N_PARTICLES-1:0]  linked_once;
  logic [ID_W-1:0]       linked_pids[$];

  rsp_t pending_results[$];

  // Stimulus memory for follow-up requests
  logic [CQ_W-1:0] last_cell = '0;
  logic [ID_W-1:0] last_pid = '0;
  logic [31:0]     last_pos [3] = '{32'd0, 32'd0, 32'd0};
  int              clears_left = 12;

  // Run statistics
  int mismatch_count = 0;
  int n_checked = 0;
  int n_binned = 0;
  int n_dropped = 0;
  int n_clears = 0;
  int n_reads = 0;
  int n_reg_writes = 0;
  int n_geometries = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic void reset_predictor();
    grid_offset    = '{32'd0, 32'd0, 32'd0};
    grid_inv_pitch = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000};
    grid_cells_x   = 13'd16;
    grid_cells_y   = 13'd16;
    head_vld       = '0;
    linked_once    = '0;
  endfunction

  // Bin one axis: false when the offset position is negative
  function automatic bit axis_bin(input logic [31:0] pos, input logic [31:0] off,
                                  input logic [31:0] inv, output logic [63:0] idx);
    logic signed [32:0] sum;
    logic [63:0]        prod;
    sum  = $signed({pos[31], pos}) + $signed({off[31], off});
    prod = {32'd0, sum[31:0]} * {32'd0, inv};
    idx  = {32'd0, prod[63:32]};
    return !sum[32];
  endfunction

  // Apply one request to the predicted lists and return its result
  function automatic rsp_t predict_binning(input req_t item);
    rsp_t              r;
    logic [63:0]       ix, iy, iz, flat;
    bit                ok;
    logic [LINK_W-1:0] old, entry;
    logic [CQ_W-1:0]   slot;
    r = '0;
    case (item.req_type)
      REQ_INSERT: begin
        ok = axis_bin(item.pos_x, grid_offset[0], grid_inv_pitch[0], ix);
        ok = axis_bin(item.pos_y, grid_offset[1], grid_inv_pitch[1], iy) && ok;
        ok = axis_bin(item.pos_z, grid_offset[2], grid_inv_pitch[2], iz) && ok;
        flat = 64'd0;
        if (ok && ix < grid_cells_x && iy < grid_cells_y) begin
          flat = ix + iy * grid_cells_x + iz * (grid_cells_x * grid_cells_y);
          ok = flat < N_CELLS;
        end else begin
          ok = 1'b0;
        end
        if (ok) begin
          slot = flat[CQ_W-1:0];
          old = head_vld[slot] ? {1'b1, head_id[slot]} : '0;
          next_link[item.particle_id] = old;
          head_id[slot] = item.particle_id;
          head_vld[slot] = 1'b1;
          if (!linked_once[item.particle_id]) begin
            linked_once[item.particle_id] = 1'b1;
            linked_pids.push_back(item.particle_id);
          end
          last_cell = slot;
          r.bin_index = slot;
          r.link = old[ID_W-1:0];
          r.link_valid = old[ID_W];
          n_binned++;
        end else begin
          r.out_of_range = 1'b1;
          n_dropped++;
        end
      end
      REQ_CLEAR: begin
        head_vld = '0;
        n_clears++;
      end
      REQ_HEAD: begin
        r.bin_index = item.cell_query;
        if (head_vld[item.cell_query]) begin
          r.link = head_id[item.cell_query];
          r.link_valid = 1'b1;
        end
        n_reads++;
      end
      REQ_LINK: begin
        entry = next_link[item.particle_id];
        if (entry[ID_W]) begin
          r.link = entry[ID_W-1:0];
          r.link_valid = 1'b1;
        end
        n_reads++;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Drive one request transaction and record its predicted result on acceptance
  task automatic send_request(input req_t item);
    @(negedge clk);
    start <= 1'b1;
    request <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_binning(item));
  endtask

  // Drop start, wait for every result, then let the pipeline settle
  task automatic wait_results_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_OFFSET_X:    grid_offset[0] = value;
      CFG_OFFSET_Y:    grid_offset[1] = value;
      CFG_OFFSET_Z:    grid_offset[2] = value;
      CFG_INV_PITCH_X: grid_inv_pitch[0] = value;
      CFG_INV_PITCH_Y: grid_inv_pitch[1] = value;
      CFG_INV_PITCH_Z: grid_inv_pitch[2] = value;
      CFG_CELLS_X:     grid_cells_x = value[12:0];
      CFG_CELLS_Y:     grid_cells_y = value[12:0];
      default: ;
    endcase
    n_reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Reprogram the whole grid once the unit is idle
  task automatic set_geometry(input logic [31:0] ox, oy, oz, px, py, pz,
                              input logic [12:0] cx, cy);
    wait_results_drained();
    write_reg(CFG_OFFSET_X, ox);
    write_reg(CFG_OFFSET_Y, oy);
    write_reg(CFG_OFFSET_Z, oz);
    write_reg(CFG_INV_PITCH_X, px);
    write_reg(CFG_INV_PITCH_Y, py);
    write_reg(CFG_INV_PITCH_Z, pz);
    write_reg(CFG_CELLS_X, {19'd0, cx});
    write_reg(CFG_CELLS_Y, {19'd0, cy});
    n_geometries++;
  endtask

  // Pick a coordinate that mostly lands inside the axis extent, sometimes near or past it
  function automatic logic [31:0] pick_position(input logic [31:0] off, input logic [31:0] inv,
                                                input logic [63:0] ncells);
    logic [63:0] span, margin, reach;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return $urandom;
    span = (inv == 32'd0) ? 64'hFFFF_FFFF : (ncells << 32) / inv;
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    margin = (roll < 25) ? span / 8 + 64'd1 : 64'd0;
    reach = span + 2 * margin;
    if (reach > 64'hFFFF_FFFF) reach = 64'hFFFF_FFFF;
    return 32'd0 - off - margin[31:0] + $urandom_range(reach[31:0]);
  endfunction

  function automatic req_t random_request();
    req_t        item;
    int unsigned pick;
    logic [63:0] area, depth;
    item.req_type    = REQ_INSERT;
    item.particle_id = ID_W'($urandom);
    item.pos_x       = $urandom;
    item.pos_y       = $urandom;
    item.pos_z       = $urandom;
    item.cell_query  = CQ_W'($urandom);
    area = grid_cells_x * grid_cells_y;
    depth = (area == 64'd0 || area > N_CELLS) ? 64'd1 : N_CELLS / area;
    pick = $urandom_range(99);
    if (pick < 2 && clears_left > 0) begin
      item.req_type = REQ_CLEAR;
      clears_left--;
    end else if (pick < 18) begin
      item.req_type = REQ_HEAD;
      if ($urandom_range(1)) item.cell_query = last_cell;
    end else if (pick < 34 && linked_pids.size() > 0) begin
      item.req_type = REQ_LINK;
      item.particle_id = linked_pids[$urandom_range(linked_pids.size() - 1)];
    end else begin
      // Reuse the last particle or position now and then to hit relinks and same-cell runs
      if ($urandom_range(3) == 0) item.particle_id = last_pid;
      if ($urandom_range(9) < 3) begin
        item.pos_x = last_pos[0];
        item.pos_y = last_pos[1];
        item.pos_z = last_pos[2];
      end else if ($urandom_range(19) != 0) begin
        item.pos_x = pick_position(grid_offset[0], grid_inv_pitch[0], {51'd0, grid_cells_x});
        item.pos_y = pick_position(grid_offset[1], grid_inv_pitch[1], {51'd0, grid_cells_y});
        item.pos_z = pick_position(grid_offset[2], grid_inv_pitch[2], depth);
      end
      last_pid = item.particle_id;
      last_pos = '{item.pos_x, item.pos_y, item.pos_z};
    end
    return item;
  endfunction

  task automatic run_random(input int count, input int idle_pct);
    repeat (count) begin
      while ($urandom_range(99) < idle_pct) begin
        @(negedge clk);
        start <= 1'b0;
      end
      send_request(random_request());
    end
  endtask

  function automatic req_t make_req(input logic [1:0] kind, input logic [ID_W-1:0] pid,
                                    input logic [31:0] x, y, z, input logic [CQ_W-1:0] cq);
    req_t item;
    item.req_type    = kind;
    item.particle_id = pid;
    item.pos_x       = x;
    item.pos_y       = y;
    item.pos_z       = z;
    item.cell_query  = cq;
    return item;
  endfunction

  // Edges of the default 16x16x16 grid, relinks, clear semantics and meaningless fields
  task automatic test_directed_requests();
    send_request(make_req(REQ_HEAD, 10'd0, 32'd0, 32'd0, 32'd0, 12'd0));
    send_request(make_req(REQ_HEAD, 10'd1023, '1, '1, '1, 12'd4095));
    send_request(make_req(REQ_INSERT, 10'd0, 32'd0, 32'd0, 32'd0, 12'd0));
    send_request(make_req(REQ_INSERT, 10'd1023, 32'd0, 32'd0, 32'd0, 12'hABC));
    send_request(make_req(REQ_INSERT, 10'd5, 32'h000F_FFFF, 32'h000F_FFFF, 32'h000F_FFFF,
                          12'd0));
    send_request(make_req(REQ_INSERT, 10'd6, 32'h0010_0000, 32'd0, 32'd0, 12'd0));
    send_request(make_req(REQ_INSERT, 10'd7, 32'd0, 32'hFFFF_FFFF, 32'd0, 12'd0));
    send_request(make_req(REQ_INSERT, 10'd8, 32'd0, 32'd0, 32'h0010_0000, 12'd0));
    send_request(make_req(REQ_INSERT, 10'd9, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          12'd0));
    send_request(make_req(REQ_INSERT, 10'd10, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          12'd0));
    send_request(make_req(REQ_INSERT, 10'd0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                          12'd0));
    send_request(make_req(REQ_HEAD, 10'd0, 32'd0, 32'd0, 32'd0, 12'd0));
    send_request(make_req(REQ_HEAD, 10'd0, 32'd0, 32'd0, 32'd0, 12'd4095));
    send_request(make_req(REQ_LINK, 10'd1023, 32'd0, 32'd0, 32'd0, 12'd0));
    send_request(make_req(REQ_LINK, 10'd5, '1, '1, '1, 12'd4095));
    send_request(make_req(REQ_LINK, 10'd0, 32'd0, 32'd0, 32'd0, 12'd0));
    // Clear with every other field set: only heads go, links stay
    send_request(make_req(REQ_CLEAR, 10'd1023, '1, '1, '1, 12'd4095));
    send_request(make_req(REQ_HEAD, 10'd0, 32'd0, 32'd0, 32'd0, 12'd0));
    send_request(make_req(REQ_LINK, 10'd1023, 32'd0, 32'd0, 32'd0, 12'd0));
    send_request(make_req(REQ_INSERT, 10'd1023, 32'd0, 32'd0, 32'd0, 12'd0));
    send_request(make_req(REQ_LINK, 10'd1023, 32'd0, 32'd0, 32'd0, 12'd0));
    send_request(make_req(REQ_HEAD, 10'd511, 32'h1234_5678, '1, 32'd0, 12'd0));
  endtask

  task automatic test_reset_geometry();
    set_geometry(32'd0, 32'd0, 32'd0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                 13'd16, 13'd16);
    run_random(120, 0);
  endtask

  task automatic test_fine_pitch_offsets();
    set_geometry(32'h0008_0000, 32'h0008_0000, 32'h0008_0000,
                 32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 13'd8, 13'd8);
    run_random(100, 60);
  endtask

  // Zero pitch and largest offset fold everything into one long chain
  task automatic test_single_column_chain();
    set_geometry(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0,
                 13'd1, 13'd1);
    run_random(60, 19);
  endtask

  task automatic test_wide_rows();
    set_geometry(32'd0, 32'd0, 32'd0, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0010_0000,
                 13'd4096, 13'd1);
    run_random(60, 60);
  endtask

  // Grids that drop every insert: negative sums, zero cell counts
  task automatic test_empty_grid();
    set_geometry(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 13'd0, 13'd8191);
    run_random(12, 19);
    set_geometry(32'd0, 32'd0, 32'd0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                 13'd8191, 13'd0);
    run_random(12, 0);
  endtask

  task automatic test_random_geometry();
    int idle_levels [3] = '{60, 19, 0};
    for (int round = 0; round < 3; round++) begin
      set_geometry(32'($urandom_range(32'h0200_0000)) - 32'h0100_0000,
                   32'($urandom_range(32'h0200_0000)) - 32'h0100_0000,
                   32'($urandom_range(32'h0200_0000)) - 32'h0100_0000,
                   $urandom_range(32'h0010_0000, 32'h0000_4000),
                   $urandom_range(32'h0010_0000, 32'h0000_4000),
                   $urandom_range(32'h0010_0000, 32'h0000_4000),
                   13'($urandom_range(64, 1)), 13'($urandom_range(64, 1)));
      run_random(50, idle_levels[round]);
    end
  endtask

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result bin_index", 32'(result.bin_index), 32'd0);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (result.bin_index !== want.bin_index)
          report_mismatch("bin_index", 32'(result.bin_index), 32'(want.bin_index));
        if (result.link !== want.link)
          report_mismatch("link", 32'(result.link), 32'(want.link));
        if (result.link_valid !== want.link_valid)
          report_mismatch("link_valid", 32'(result.link_valid), 32'(want.link_valid));
        if (result.out_of_range !== want.out_of_range)
          report_mismatch("out_of_range", 32'(result.out_of_range),
                          32'(want.out_of_range));
      end
    end
  end

  initial begin
    reset_predictor();
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    test_directed_requests();
    test_reset_geometry();
    test_fine_pitch_offsets();
    test_single_column_chain();
    test_wide_rows();
    test_empty_grid();
    test_random_geometry();
    wait_results_drained();
    repeat (16) @(posedge clk);
    $display("Summary: %0d results checked: %0d inserts binned, %0d dropped, %0d clears, %0d reads",
             n_checked, n_binned, n_dropped, n_clears, n_reads);
    $display("Summary: %0d register writes over %0d grid geometries, sender idle 0/19/60 pct",
             n_reg_writes, n_geometries);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
